// ===== rtl/t2s_pkg.sv =====
package t2s_pkg;

    localparam int CORDIC_STEPS = 16;
    localparam int TABLE_LEN    = 24;
    localparam int NUM_STEPS    = (CORDIC_STEPS < TABLE_LEN) ? CORDIC_STEPS : TABLE_LEN;
    localparam int STEP_W       = 5;

    localparam int VEC_W = 26;
    localparam int ACC_W = 25;

    localparam int DIVIDEND_W = 29;
    localparam int DIVISOR_W  = 8;
    localparam int DCOUNT_W   = 5;

    localparam logic [15:0] Z_FLOOR = 16'd205;

    localparam logic [2:0] REG_ANGLE_RANGE = 3'd0;
    localparam logic [2:0] REG_SERVO_X_MIN = 3'd1;
    localparam logic [2:0] REG_SERVO_X_MAX = 3'd2;
    localparam logic [2:0] REG_SERVO_Y_MIN = 3'd3;
    localparam logic [2:0] REG_SERVO_Y_MAX = 3'd4;
    localparam logic [2:0] REG_SMOOTHING   = 3'd5;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ANGLE,
        ST_MUL,
        ST_DIV,
        ST_FILT_MUL,
        ST_FILT_SUM,
        ST_OUT
    } t2s_state_t;

    // atan(2^-i) in degrees scaled by 65536.
    function automatic logic [22:0] atan_deg(input logic [STEP_W-1:0] idx);
        logic [22:0] v;
        case (idx)
            5'd0:  v = 23'd2949120;
            5'd1:  v = 23'd1740967;
            5'd2:  v = 23'd919879;
            5'd3:  v = 23'd466945;
            5'd4:  v = 23'd234379;
            5'd5:  v = 23'd117304;
            5'd6:  v = 23'd58666;
            5'd7:  v = 23'd29335;
            5'd8:  v = 23'd14668;
            5'd9:  v = 23'd7334;
            5'd10: v = 23'd3667;
            5'd11: v = 23'd1833;
            5'd12: v = 23'd917;
            5'd13: v = 23'd458;
            5'd14: v = 23'd229;
            5'd15: v = 23'd115;
            5'd16: v = 23'd57;
            5'd17: v = 23'd29;
            5'd18: v = 23'd14;
            5'd19: v = 23'd7;
            5'd20: v = 23'd4;
            5'd21: v = 23'd2;
            5'd22: v = 23'd1;
            default: v = 23'd0;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/t2s_cordic.sv =====
module t2s_cordic
    import t2s_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [15:0] num,
    input  logic signed [15:0] den,
    output logic               done,
    output logic signed [15:0] angle
);

    logic signed [VEC_W-1:0]  vx_reg, vy_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic [STEP_W-1:0]        step_reg;
    logic                     busy_reg, done_reg;
    logic signed [16:0]       den_mag, num_adj;
    logic signed [ACC_W-1:0]  rnd;
    logic signed [VEC_W-1:0]  sx, sy;
    logic signed [ACC_W-1:0]  at;

    // The vector is folded into the right half plane before rotation.
    assign den_mag = den[15] ? -{den[15], den} : {den[15], den};
    assign num_adj = den[15] ? -{num[15], num} : {num[15], num};
    assign sx = vx_reg >>> step_reg;
    assign sy = vy_reg >>> step_reg;
    assign at = ACC_W'(signed'({1'b0, atan_deg(step_reg)}));
    assign rnd = (acc_reg + ACC_W'(128)) >>> 8;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg &&
                         (vy_reg == '0 || step_reg == STEP_W'(NUM_STEPS - 1) ||
                          NUM_STEPS == 0)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            vx_reg   <= VEC_W'(den_mag) <<< 8;
            vy_reg   <= VEC_W'(num_adj) <<< 8;
            acc_reg  <= '0;
            step_reg <= '0;
        end else if (busy_reg && vy_reg != '0) begin
            if (vy_reg > 0) begin
                vx_reg  <= vx_reg + sy;
                vy_reg  <= vy_reg - sx;
                acc_reg <= acc_reg + at;
            end else begin
                vx_reg  <= vx_reg - sy;
                vy_reg  <= vy_reg + sx;
                acc_reg <= acc_reg - at;
            end
            step_reg <= step_reg + STEP_W'(1);
        end
    end

    assign done  = done_reg;
    assign angle = rnd[15:0];

endmodule

// ===== rtl/t2s_div.sv =====
module t2s_div
    import t2s_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [DIVIDEND_W-1:0] dividend,
    input  logic [DIVISOR_W-1:0]  divisor,
    output logic                  done,
    output logic [DIVIDEND_W-1:0] quotient
);

    logic [DIVIDEND_W-1:0] quo_reg;
    logic [DIVISOR_W-1:0]  rem_reg, dvs_reg;
    logic [DCOUNT_W-1:0]   cnt_reg;
    logic                  busy_reg, done_reg;
    logic [DIVISOR_W:0]    trial;
    logic                  fits;

    // Restoring division, one quotient bit per cycle.
    assign trial = {rem_reg, quo_reg[DIVIDEND_W-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == DCOUNT_W'(DIVIDEND_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            rem_reg <= fits ? DIVISOR_W'(trial - {1'b0, dvs_reg}) : trial[DIVISOR_W-1:0];
            quo_reg <= {quo_reg[DIVIDEND_W-2:0], fits};
            cnt_reg <= cnt_reg + DCOUNT_W'(1);
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

// ===== rtl/tilt_to_servo_lowpass_top.sv =====
// Turns one accelerometer sample into two tilt angles (Q8.8 degrees, clamped to the
// configured range) and two smoothed servo commands. The block takes one request at a
// time: s_tready is high only while it is idle, and the result is held on the master
// side until it is taken. The time a sample takes is set by the iterative CORDIC
// unit and the bit-serial divider, each shared by the x and y axes in turn (the
// CORDIC finishes early when the vector lands on the axis). The first sample after
// reset loads the filters directly; later ones blend with coefficient smoothing/256,
// with smoothing saturated at 256. Configuration writes should be made while the
// block is idle.
module tilt_to_servo_lowpass_top
    import t2s_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [55:0] m_tdata,   // tilt_x, tilt_y, servo_x_cmd, servo_y_cmd
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [11:0] cfg_wdata
);

    // Configuration registers.
    logic [6:0]  angle_range_reg;
    logic [11:0] servo_x_min_reg, servo_x_max_reg, servo_y_min_reg, servo_y_max_reg;
    logic [8:0]  smoothing_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_range_reg <= 7'd90;
            servo_x_min_reg <= 12'd0;
            servo_x_max_reg <= 12'd180;
            servo_y_min_reg <= 12'd0;
            servo_y_max_reg <= 12'd180;
            smoothing_reg   <= 9'd77;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_ANGLE_RANGE: angle_range_reg <= cfg_wdata[6:0];
                REG_SERVO_X_MIN: servo_x_min_reg <= cfg_wdata;
                REG_SERVO_X_MAX: servo_x_max_reg <= cfg_wdata;
                REG_SERVO_Y_MIN: servo_y_min_reg <= cfg_wdata;
                REG_SERVO_Y_MAX: servo_y_max_reg <= cfg_wdata;
                REG_SMOOTHING:   smoothing_reg   <= cfg_wdata[8:0];
                default: ;
            endcase
        end
    end

    // Effective range (zero counts as one degree) and alpha (saturated at 256).
    logic [6:0]  range_eff;
    logic [8:0]  alpha;
    logic [14:0] lim;
    assign range_eff = (angle_range_reg == '0) ? 7'd1 : angle_range_reg;
    assign alpha     = (smoothing_reg > 9'd256) ? 9'd256 : smoothing_reg;
    assign lim       = {range_eff, 8'd0};

    // Sequencer state.
    t2s_state_t state_reg, state_next;
    logic axis_reg, axis_next;
    logic primed_reg, primed_next;

    logic signed [15:0] ax_reg, ay_reg, az_reg;
    logic signed [15:0] tilt_x_reg, tilt_y_reg;
    logic signed [16:0] num_reg;
    logic signed [30:0] prod_reg;
    logic [19:0] cmd_reg;
    logic [28:0] m1_reg, m2_reg;
    logic [19:0] filter_x_reg, filter_y_reg;

    // Start pulses for the two shared units, registered so that each unit sees its
    // operands already settled.
    logic angle_go_reg, div_go_reg;

    // Floor on |z| so that the angle stays defined near the horizon.
    logic signed [15:0] az_in, az_fl;
    logic [16:0]        az_mag;
    assign az_in  = s_tdata[47:32];
    assign az_mag = az_in[15] ? 17'(-{az_in[15], az_in}) : {1'b0, az_in};
    assign az_fl  = (az_mag < {1'b0, Z_FLOOR}) ?
                    ((az_in > 0) ? signed'(Z_FLOOR) : -signed'(Z_FLOOR)) : az_in;

    // Shared CORDIC unit.
    logic cordic_done;
    logic signed [15:0] cordic_angle;
    t2s_cordic u_cordic (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (angle_go_reg),
        .num     (axis_reg ? ay_reg : ax_reg),
        .den     (az_reg),
        .done    (cordic_done),
        .angle   (cordic_angle)
    );

    // Shared divider for the linear mapping.
    logic div_done;
    logic [DIVIDEND_W-1:0] div_q;
    logic [30:0] prod_mag;
    assign prod_mag = prod_reg[30] ? 31'(-prod_reg) : prod_reg;
    t2s_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_go_reg),
        .dividend (prod_mag[DIVIDEND_W-1:0]),
        .divisor  ({range_eff, 1'b0}),
        .done     (div_done),
        .quotient (div_q)
    );

    // Angle clamp and mapping numerator for the axis in hand.
    logic signed [16:0] ang_ext, lim_s, ang_cl;
    assign ang_ext = {cordic_angle[15], cordic_angle};
    assign lim_s   = {2'b00, lim};
    assign ang_cl  = (ang_ext < -lim_s) ? -lim_s : ((ang_ext > lim_s) ? lim_s : ang_ext);

    logic [11:0] lo, hi;
    assign lo = axis_reg ? servo_y_min_reg : servo_x_min_reg;
    assign hi = axis_reg ? servo_y_max_reg : servo_x_max_reg;

    logic signed [12:0] diff;
    assign diff = signed'({1'b0, hi}) - signed'({1'b0, lo});

    // Command in Q12.8 from the quotient, then clamped to the servo span.
    logic signed [22:0] q_s, cmd_raw, lo8, hi8;
    logic [19:0] cmd_cl;
    assign q_s     = prod_reg[30] ? -signed'({2'b00, div_q[20:0]})
                                  : signed'({2'b00, div_q[20:0]});
    assign lo8     = signed'({3'b000, lo, 8'd0});
    assign hi8     = signed'({3'b000, hi, 8'd0});
    assign cmd_raw = lo8 + q_s;
    assign cmd_cl  = (cmd_raw < lo8) ? lo8[19:0] : ((cmd_raw > hi8) ? hi8[19:0] : cmd_raw[19:0]);

    logic [19:0] f_old;
    logic [29:0] f_sum;
    assign f_old = axis_reg ? filter_y_reg : filter_x_reg;
    assign f_sum = 30'(m1_reg) + 30'(m2_reg) + 30'd128;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            axis_reg   <= 1'b0;
            primed_reg <= 1'b0;
        end else begin
            state_reg  <= state_next;
            axis_reg   <= axis_next;
            primed_reg <= primed_next;
        end
    end

    always_comb begin
        state_next   = state_reg;
        axis_next    = axis_reg;
        primed_next  = primed_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    axis_next  = 1'b0;
                    state_next = ST_ANGLE;
                end
            end
            ST_ANGLE: begin
                if (cordic_done) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL: begin
                state_next = ST_DIV;
            end
            ST_DIV: begin
                if (div_done) begin
                    state_next = ST_FILT_MUL;
                end
            end
            ST_FILT_MUL: begin
                state_next = ST_FILT_SUM;
            end
            ST_FILT_SUM: begin
                if (!axis_reg) begin
                    axis_next  = 1'b1;
                    state_next = ST_ANGLE;
                end else begin
                    primed_next = 1'b1;
                    state_next  = ST_OUT;
                end
            end
            ST_OUT: begin
                if (m_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // The CORDIC fires on the first cycle of ST_ANGLE, once the axis and operands are
    // in place. The divider fires on the first cycle of ST_DIV, after the product has
    // been registered in ST_MUL.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            angle_go_reg <= 1'b0;
            div_go_reg   <= 1'b0;
        end else begin
            angle_go_reg <= (state_reg != ST_ANGLE) && (state_next == ST_ANGLE);
            div_go_reg   <= (state_reg == ST_MUL);
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_IDLE && s_tvalid) begin
            ax_reg <= s_tdata[15:0];
            ay_reg <= s_tdata[31:16];
            az_reg <= az_fl;
        end
        if (state_reg == ST_ANGLE && cordic_done) begin
            if (axis_reg) begin
                tilt_y_reg <= ang_cl[15:0];
            end else begin
                tilt_x_reg <= ang_cl[15:0];
            end
            num_reg <= ang_cl + lim_s;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= 31'(num_reg * 31'(diff));
        end
        if (state_reg == ST_DIV && div_done) begin
            cmd_reg <= cmd_cl;
        end
        if (state_reg == ST_FILT_MUL) begin
            m1_reg <= 29'(cmd_reg) * 29'(alpha);
            m2_reg <= 29'(f_old) * 29'(9'd256 - alpha);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_x_reg <= '0;
            filter_y_reg <= '0;
        end else if (state_reg == ST_FILT_SUM) begin
            if (axis_reg) begin
                filter_y_reg <= primed_reg ? f_sum[27:8] : cmd_reg;
            end else begin
                filter_x_reg <= primed_reg ? f_sum[27:8] : cmd_reg;
            end
        end
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = (state_reg == ST_OUT);
    assign m_tdata  = {filter_y_reg[19:8], filter_x_reg[19:8], tilt_y_reg, tilt_x_reg};

endmodule

// ===== test/tb.sv =====
module tb
    import t2s_pkg::*;
();

    // Clock, reset, the two stream channels and the configuration port of the block.
    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [47:0] s_tdata;   // accel_x [15:0], accel_y [31:16], accel_z [47:32]
    logic        m_tvalid;
    logic        m_tready;
    logic [55:0] m_tdata;   // tilt_x [15:0], tilt_y [31:16], servo_x_cmd [43:32],
                            // servo_y_cmd [55:44]
    logic        cfg_wr_en;
    logic [2:0]  cfg_index;
    logic [11:0] cfg_wdata;

    // This margin covers the time that one sample takes well.
    localparam int SETTLE_CYCLES = 400;
    localparam int PHASES        = 11;
    localparam int PHASE_ITEMS   = 118;

    // Scoreboard: keeps its own copy of the registers and the filter state, works out
    // the expected result of each accepted request and compares the block's output.
    class servo_scoreboard;
        // atan(2^-i) in degrees scaled by 65536.
        longint unsigned atan_lut[24] = '{
            2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
            14668, 7334, 3667, 1833, 917, 458, 229, 115,
            57, 29, 14, 7, 4, 2, 1, 0};
        logic [6:0]  range_deg;
        logic [11:0] x_lo, x_hi, y_lo, y_hi;
        logic [8:0]  alpha_q8;
        logic [19:0] filt_x, filt_y;
        bit          primed;
        logic [55:0] expected_q[$];
        int          errors;

        function new();
            range_deg = 7'd90;
            x_lo = 12'd0; x_hi = 12'd180; y_lo = 12'd0; y_hi = 12'd180;
            alpha_q8 = 9'd77;
            filt_x = '0; filt_y = '0;
            primed = 1'b0;
            errors = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [11:0] val);
            case (idx)
                REG_ANGLE_RANGE: range_deg = val[6:0];
                REG_SERVO_X_MIN: x_lo = val;
                REG_SERVO_X_MAX: x_hi = val;
                REG_SERVO_Y_MIN: y_lo = val;
                REG_SERVO_Y_MAX: y_hi = val;
                REG_SMOOTHING:   alpha_q8 = val[8:0];
                default: ;
            endcase
        endfunction

        // Vectoring CORDIC on (|den|, sign(den)*num), angle rounded to Q8.8 degrees.
        function longint tilt_q88(longint num, longint den);
            longint vx, vy, acc, nx, ny;
            vx = (den < 0 ? -den : den) * 256;
            vy = (den < 0 ? -num : num) * 256;
            acc = 0;
            for (int i = 0; i < NUM_STEPS; i++) begin
                if (vy > 0) begin
                    nx = vx + (vy >>> i);
                    ny = vy - (vx >>> i);
                    acc += longint'(atan_lut[i]);
                end else if (vy < 0) begin
                    nx = vx - (vy >>> i);
                    ny = vy + (vx >>> i);
                    acc -= longint'(atan_lut[i]);
                end else begin
                    break;
                end
                vx = nx;
                vy = ny;
            end
            return (acc + 128) >>> 8;
        endfunction

        // Linear map of the clamped angle onto the servo span, Q12.8.
        function longint servo_q8(longint ang, longint rng, longint lo, longint hi);
            longint cmd;
            cmd = lo * 256 + ((ang + rng * 256) * (hi - lo) * 256) / (rng * 512);
            if (cmd < lo * 256)
                cmd = lo * 256;
            else if (cmd > hi * 256)
                cmd = hi * 256;
            return cmd;
        endfunction

        function void note_sample(logic [47:0] d);
            longint ax, ay, az, rng, lim, alpha, tx, ty, cx, cy;
            ax = longint'($signed(d[15:0]));
            ay = longint'($signed(d[31:16]));
            az = longint'($signed(d[47:32]));
            rng = (range_deg == 0) ? 1 : longint'(range_deg);
            lim = rng * 256;
            alpha = (alpha_q8 > 256) ? 256 : longint'(alpha_q8);
            // A z reading near zero is pushed out to the floor, keeping its sign;
            // zero itself counts as negative.
            if ((az < 0 ? -az : az) < 205)
                az = (az > 0) ? 205 : -205;
            tx = tilt_q88(ax, az);
            ty = tilt_q88(ay, az);
            if (tx < -lim) tx = -lim;
            if (tx > lim) tx = lim;
            if (ty < -lim) ty = -lim;
            if (ty > lim) ty = lim;
            cx = servo_q8(tx, rng, longint'(x_lo), longint'(x_hi));
            cy = servo_q8(ty, rng, longint'(y_lo), longint'(y_hi));
            if (!primed) begin
                filt_x = cx[19:0];
                filt_y = cy[19:0];
                primed = 1'b1;
            end else begin
                filt_x = 20'((cx * alpha + longint'(filt_x) * (256 - alpha) + 128) >> 8);
                filt_y = 20'((cy * alpha + longint'(filt_y) * (256 - alpha) + 128) >> 8);
            end
            expected_q.push_back({filt_y[19:8], filt_x[19:8], ty[15:0], tx[15:0]});
        endfunction

        function void check_result(logic [55:0] got);
            logic [55:0] exp;
            if (expected_q.size() == 0) begin
                $error("result with no request outstanding: %h", got);
                errors++;
                return;
            end
            exp = expected_q.pop_front();
            if (got[15:0] !== exp[15:0]) begin
                $error("tilt_x expected %0d got %0d", $signed(exp[15:0]), $signed(got[15:0]));
                errors++;
            end
            if (got[31:16] !== exp[31:16]) begin
                $error("tilt_y expected %0d got %0d",
                       $signed(exp[31:16]), $signed(got[31:16]));
                errors++;
            end
            if (got[43:32] !== exp[43:32]) begin
                $error("servo_x_cmd expected %0d got %0d", exp[43:32], got[43:32]);
                errors++;
            end
            if (got[55:44] !== exp[55:44]) begin
                $error("servo_y_cmd expected %0d got %0d", exp[55:44], got[55:44]);
                errors++;
            end
        endfunction
    endclass

    servo_scoreboard sb;
    int burst_left;
    int rx_mode;
    int rx_count;

    tilt_to_servo_lowpass_top u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Both monitors sample at the rising edge, so they see the values that were
    // settled before it and never race with the block's own updates.
    always @(posedge aclk) begin
        if (aresetn && s_tvalid && s_tready)
            sb.note_sample(s_tdata);
        if (aresetn && m_tvalid && m_tready)
            sb.check_result(m_tdata);
    end

    // The receiver changes its stall pattern now and then: always ready, coin toss,
    // mostly stalled, or ready only when the low two bits of a counter are zero.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
            rx_mode  <= 0;
            rx_count <= 0;
        end else begin
            rx_count <= rx_count + 1;
            if ($urandom_range(0, 399) == 0)
                rx_mode <= $urandom_range(0, 3);
            case (rx_mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                2: m_tready <= ($urandom_range(0, 7) == 0);
                default: m_tready <= (rx_count[1:0] == 2'd0);
            endcase
        end
    end

    // Presents one request and holds it until it is taken. Requests come in bursts of
    // random length; between bursts the valid line often drops for a random gap.
    task automatic send_sample(logic [15:0] ax, logic [15:0] ay, logic [15:0] az);
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            if ($urandom_range(0, 2) != 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 150)) @(posedge aclk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {az, ay, ax};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        burst_left--;
    endtask

    // Registers are only touched once every result is home and the block has had
    // time to fall idle. A clock edge passes first so that the last request has been
    // noted by the scoreboard.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(logic [2:0] idx, logic [11:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge aclk);
        sb.write_reg(idx, val);
    endtask

    task automatic load_settings(logic [6:0] rng, logic [11:0] xl, logic [11:0] xh,
                                 logic [11:0] yl, logic [11:0] yh, logic [8:0] alpha);
        wait_idle();
        write_reg(REG_ANGLE_RANGE, {5'd0, rng});
        write_reg(REG_SERVO_X_MIN, xl);
        write_reg(REG_SERVO_X_MAX, xh);
        write_reg(REG_SERVO_Y_MIN, yl);
        write_reg(REG_SERVO_Y_MAX, yh);
        write_reg(REG_SMOOTHING, {3'd0, alpha});
        cfg_wr_en <= 1'b0;
    endtask

    // Most samples look like a real sensor at rest or tilting; some are raw noise and
    // some hold z close to zero, where the floor substitution comes into play.
    task automatic send_random();
        logic [15:0] ax, ay, az;
        int pick;
        pick = $urandom_range(0, 9);
        ax = 16'($urandom);
        ay = 16'($urandom);
        az = 16'($urandom);
        if (pick < 6) begin
            ax = 16'($signed($urandom_range(0, 40000)) - 20000);
            ay = 16'($signed($urandom_range(0, 40000)) - 20000);
            az = 16'($urandom_range(1000, 32767));
            if ($urandom_range(0, 3) == 0)
                az = -az;
        end else if (pick < 8) begin
            az = 16'($signed($urandom_range(0, 800)) - 400);
        end
        send_sample(ax, ay, az);
    endtask

    initial begin
        logic [15:0] edge_vals[8];
        sb = new();
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_wdata  = '0;
        burst_left = 0;
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part under the reset settings: the first request loads the
        // filter, then extremes of every field and the z floor on both sides.
        send_sample(16'd1000, -16'sd1000, 16'd16384);
        send_sample(16'h7FFF, 16'h8000, 16'd1);
        send_sample(16'h8000, 16'h7FFF, 16'hFFFF);
        send_sample(16'd5000, 16'd5000, 16'd0);
        send_sample(16'd5000, -16'sd5000, 16'd204);
        send_sample(16'd5000, -16'sd5000, -16'sd204);
        send_sample(16'd5000, -16'sd5000, 16'd205);
        send_sample(16'd5000, -16'sd5000, -16'sd205);
        send_sample(16'd0, 16'd0, 16'h8000);
        send_sample(16'd0, 16'd0, 16'h7FFF);
        send_sample(16'h7FFF, 16'h7FFF, 16'h7FFF);
        send_sample(16'h8000, 16'h8000, 16'h8000);
        send_sample(16'hFFFF, 16'h0001, 16'h7FFF);
        send_sample(16'h5555, 16'hAAAA, 16'h2AAA);

        // Extreme settings: narrowest range with a full x span and y minimum above maximum,
        // the widest the field allows with an empty span, zero range with minimum above
        // maximum, and the smoothing at zero, at 256 and above it.
        load_settings(7'd1, 12'd0, 12'd4095, 12'd4095, 12'd0, 9'd256);
        edge_vals = '{16'h7FFF, 16'h8000, 16'd0, 16'd1, 16'hFFFF, 16'd300, 16'hFED4, 16'd205};
        for (int i = 0; i < 8; i++)
            send_sample(edge_vals[i], edge_vals[7 - i], edge_vals[(i + 3) % 8]);
        load_settings(7'd127, 12'd4095, 12'd4095, 12'd0, 12'd0, 9'd0);
        for (int i = 0; i < 3; i++)
            send_random();
        load_settings(7'd0, 12'd3000, 12'd1000, 12'd200, 12'd100, 9'd511);
        for (int i = 0; i < 3; i++)
            send_random();

        // Random phases, each under fresh settings with a bias towards the limits.
        for (int p = 0; p < PHASES; p++) begin
            case (p % 4)
                0: load_settings(7'd90, 12'd0, 12'd180, 12'd0, 12'd180, 9'd77);
                1: load_settings(7'($urandom_range(1, 90)), 12'($urandom_range(0, 1000)),
                                 12'($urandom_range(1000, 4095)),
                                 12'($urandom_range(0, 1000)),
                                 12'($urandom_range(1000, 4095)),
                                 9'($urandom_range(1, 256)));
                2: load_settings(7'($urandom), 12'($urandom), 12'($urandom),
                                 12'($urandom), 12'($urandom), 9'($urandom));
                default: load_settings(7'($urandom_range(85, 127)), 12'd0, 12'd4095,
                                       12'd4095, 12'd0, 9'($urandom_range(250, 511)));
            endcase
            for (int i = 0; i < PHASE_ITEMS; i++)
                send_random();
        end

        // Drain: everything outstanding must come back, then a quiet stretch in which
        // any stray result would still be caught.
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

    // Watchdog, far beyond the slowest correct run.
    initial begin
        #20000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/t2s_pkg.sv
rtl/t2s_cordic.sv
rtl/t2s_div.sv
rtl/tilt_to_servo_lowpass_top.sv
test/tb.sv
